@@ rtl/core/assert_macros.svh @@
// Assertion macros for the positional list block.
// Each macro expects i_clk to be visible where it is used, and PLD_ASSERT also i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is asserted.
`define PLD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pld: assertion failed");

// Checked property that also holds during reset.
`define PLD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pld: reset assertion failed");

`else

`define PLD_ASSERT(lbl, prop)
`define PLD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/core/pld_pkg.sv @@
package pld_pkg;

    // Payload widths of the two channels.
    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int LEN_W = 5;
    localparam int ST_W  = 2;

    localparam int CAPACITY_DEF = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_pld_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_pld_cmd;

endpackage

@@ rtl/core/pld_if.sv @@
interface pld_in_if
    import pld_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

interface pld_out_if
    import pld_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
    logic [ST_W-1:0]         status;

    modport source (output valid, output read_value, output length, output status,
                    input ready);
    modport sink   (input valid, input read_value, input length, input status,
                    output ready);
endinterface

@@ rtl/core/pld_ctrl.sv @@
module pld_ctrl
    import pld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_pld_cmd o_cmd
);

    t_pld_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register must be free or emptying this cycle.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.exec | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/pld_dp.sv @@
module pld_dp
    import pld_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pld_cmd                i_cmd,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [LEN_W-1:0]        o_length,
    output logic [ST_W-1:0]         o_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int AW = $clog2(CAPACITY);

    logic [OP_W-1:0]         r_op;
    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_val;
    logic [CW-1:0]           r_count, n_count;
    logic signed [VAL_W-1:0] r_cells [CAPACITY];
    logic signed [VAL_W-1:0] n_cells [CAPACITY];
    logic signed [VAL_W-1:0] r_read_value, n_read_value;
    logic [LEN_W-1:0]        r_length;
    logic [ST_W-1:0]         r_status, n_status;

    logic [PW-1:0] pos_w, cnt_w, ins_pos;
    logic          is_ins, range_err, full, ins_ok, del_ok, rd_ok;
    logic [AW-1:0] rd_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_cells      <= n_cells;
            r_read_value <= n_read_value;
            r_length     <= LEN_W'(n_count);
            r_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Operation decode. Append is an insert at the current end of the list.
    always_comb begin
        pos_w   = PW'(r_pos);
        cnt_w   = PW'(r_count);
        full    = (cnt_w >= PW'(CAPACITY));
        is_ins  = (r_op == OP_APPEND) || (r_op == OP_INSERT);
        ins_pos = (r_op == OP_APPEND) ? cnt_w : pos_w;
        if (is_ins) begin
            range_err = (r_op == OP_INSERT) && (pos_w > cnt_w);
        end else begin
            range_err = (pos_w == '0) || (pos_w > cnt_w);
        end
        ins_ok = is_ins && !range_err && !full;
        del_ok = (r_op == OP_DELETE) && !range_err;
        rd_ok  = (r_op == OP_READ) && !range_err;
        rd_idx = AW'(pos_w - PW'(1));

        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (del_ok) begin
            n_count = r_count - CW'(1);
        end

        priority if (range_err) begin
            n_status = ST_RANGE;
        end else if (is_ins && full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_DONE;
        end

        n_read_value = rd_ok ? r_cells[rd_idx] : '0;
    end

    // Each cell keeps its value, takes a neighbor, or takes the new value.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [PW-1:0] K   = PW'(g);
        localparam logic [PW-1:0] KP1 = PW'(g + 1);
        logic signed [VAL_W-1:0] w_lower, w_upper;

        if (g > 0) begin : g_lower
            assign w_lower = r_cells[g-1];
        end else begin : g_no_lower
            assign w_lower = r_cells[g];
        end

        if (g < CAPACITY - 1) begin : g_upper
            assign w_upper = r_cells[g+1];
        end else begin : g_no_upper
            assign w_upper = r_cells[g];
        end

        always_comb begin
            n_cells[g] = r_cells[g];
            if (ins_ok && (K == ins_pos)) begin
                n_cells[g] = r_val;
            end else if (ins_ok && (K > ins_pos) && (K <= cnt_w)) begin
                n_cells[g] = w_lower;
            end else if (del_ok && (KP1 >= pos_w) && (KP1 < cnt_w)) begin
                n_cells[g] = w_upper;
            end
        end
    end

    assign o_read_value = r_read_value;
    assign o_length     = r_length;
    assign o_status     = r_status;

endmodule

@@ rtl/core/positional_list_insert_delete.sv @@
// Positional list: holds an ordered sequence of up to CAPACITY signed 32-bit
// values and performs one operation per input transaction: append, insert
// after a one-based position (0 inserts at the front), delete at a position,
// or read at a position. Each input transaction yields exactly one output
// transaction carrying read_value, the resulting length and a status code
// (done, position out of range, or list full).
// Both channels use valid/ready; a transaction moves on a rising edge where
// both are high. An accepted item is first captured into the operand
// registers, then executed once the result register is free: the cell array
// shifts and the result register loads, and the result is offered from then
// on. The block works on one item at a time and takes no new item until the
// last one has executed. Input ready is high whenever the controller is
// idle, even while an earlier result waits; if the receiver stalls, the next
// item waits in execution until the result register frees.
// Reset (synchronous, active low) empties the list and drops any pending
// result; the element storage itself is not cleared.
module positional_list_insert_delete
    import pld_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pld_in_if.sink     i_in,
    pld_out_if.source  o_out
);

    // Length reported while the list is full.
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

    t_pld_cmd cmd;

    // The controller sequences capture, execution and the output handshake.
    pld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the element cells, the count and the result register.
    pld_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operation  (i_in.operation),
        .i_position   (i_in.position),
        .i_value      (i_in.value),
        .o_read_value (o_out.read_value),
        .o_length     (o_out.length),
        .o_status     (o_out.status)
    );

`include "assert_macros.svh"

    // Only one item is in flight: after an accepted transaction, input is held off.
    `PLD_ASSERT(a_one_in_flight, (i_in.valid && i_in.ready) |=> !i_in.ready)
    // A full status is only reported when the list holds CAPACITY elements.
    `PLD_ASSERT(a_full_len, o_out.valid && o_out.status == ST_FULL |-> o_out.length == FULL_LEN)
    // A result appears only after an execution cycle, while input is held off.
    `PLD_ASSERT(a_valid_after_exec, $rose(o_out.valid) |-> $past(!i_in.ready))
    // Reset drops any pending result.
    `PLD_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out.valid)

endmodule
